/* hdl/integer_to_ascii_converter_defines.svh */
// Assertion macros shared by the checker of the integer to ASCII converter.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef INTEGER_TO_ASCII_CONVERTER_DEFINES_SVH
`define INTEGER_TO_ASCII_CONVERTER_DEFINES_SVH

// Checked on every clock edge outside of reset.
`define ITOA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define ITOA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/itoa_pkg.sv */
// Types, character codes and helper functions of the integer to ASCII converter.
// No dependencies; the front end, queue, back end and top level import this package.
package itoa_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CNT_W      = 6;   // holds 0 to VALUE_BITS
  localparam int unsigned IDX_W      = 5;   // indexes VALUE_BITS digits
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W     = 1;
  localparam int unsigned QCNT_W     = 2;

  // floor(x / 10) == (x * DEC_RECIP) >> DEC_SHIFT for every 32-bit x.
  localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned DEC_SHIFT = 35;
  localparam int unsigned QUO_W     = 2 * VALUE_BITS - DEC_SHIFT;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [3:0] LAST_DEC_DIGIT = 4'd9;
  localparam logic [3:0] HEX_TEN    = 4'hA;

  typedef enum logic [2:0] {
    BASE_HEX = 3'b001,
    BASE_DEC = 3'b010,
    BASE_BIN = 3'b100
  } itoa_base_t;

  // One classified conversion job as it travels from the front to the back.
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    itoa_base_t            base;
    logic [7:0]            fill_ch;
    logic                  has_sign;
    logic [7:0]            sign_ch;
    logic [CNT_W-1:0]      width;
  } itoa_job_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } itoa_q_status_t;

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] ch;
    if (d <= LAST_DEC_DIGIT) begin
      ch = CH_ZERO + 8'(d);
    end else begin
      ch = CH_LOWER_A + 8'(d - HEX_TEN);
    end
    return ch;
  endfunction

endpackage

/* hdl/itoa_in_if.sv */
// Input channel of the integer to ASCII converter: one number and its format.
// No dependencies.
interface itoa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [1:0]  base_select;
  logic        zero_fill;
  logic [1:0]  sign_mode;
  logic [5:0]  field_width;

  modport source (output valid, value, base_select, zero_fill, sign_mode, field_width,
                  input ready);
  modport sink (input valid, value, base_select, zero_fill, sign_mode, field_width,
                output ready);
endinterface

/* hdl/itoa_out_if.sv */
// Result channel of the integer to ASCII converter: one character per transfer.
// No dependencies.
interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;

  modport source (output valid, char_out, last, input ready);
  modport sink (input valid, char_out, last, output ready);
endinterface

/* hdl/itoa_front.sv */
// Front end: takes input transfers, decodes base, fill, sign and width into a job.
// Depends on itoa_pkg and itoa_in_if.
module itoa_front import itoa_pkg::*; #(
  parameter int MAX_DIGITS = 32
) (
  itoa_in_if.sink        in_ch,
  input  itoa_q_status_t q_status,
  output logic           push,
  output itoa_job_t      push_job
);

  localparam int WIDTH_CAP = (MAX_DIGITS < int'(VALUE_BITS)) ? MAX_DIGITS : int'(VALUE_BITS);
  localparam logic [CNT_W-1:0] WIDTH_CAP_C = CNT_W'(WIDTH_CAP);

  assign in_ch.ready = !q_status.full;
  assign push        = in_ch.valid && !q_status.full;

  always_comb begin
    push_job.value = in_ch.value;
    // Binary wins over decimal when both select bits are set.
    if (in_ch.base_select[1]) begin
      push_job.base = BASE_BIN;
    end else if (in_ch.base_select[0]) begin
      push_job.base = BASE_DEC;
    end else begin
      push_job.base = BASE_HEX;
    end
    push_job.fill_ch  = in_ch.zero_fill ? CH_ZERO : CH_SPACE;
    push_job.has_sign = |in_ch.sign_mode;
    push_job.sign_ch  = in_ch.sign_mode[1] ? CH_MINUS : CH_PLUS;
    push_job.width    = (in_ch.field_width > WIDTH_CAP_C) ? WIDTH_CAP_C : in_ch.field_width;
  end

endmodule

/* hdl/itoa_queue.sv */
// Two-entry job queue between the front end and the conversion back end.
// Depends on itoa_pkg.
module itoa_queue import itoa_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  itoa_job_t      push_job,
  input  logic           pop,
  output itoa_job_t      pop_job,
  output itoa_q_status_t status
);

  itoa_job_t         entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign status.full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.nonempty = (count_r != '0);
  assign pop_job         = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* hdl/itoa_back.sv */
// Back end: generates digits one per step into a register file, then sends
// fill, sign and digits through the output register. Depends on itoa_pkg, itoa_out_if.
module itoa_back import itoa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  input  itoa_job_t job,
  output logic      job_pop,
  itoa_out_if.source out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIG  = 4'b0100,
    ST_EMIT = 4'b1000
  } back_state_t;

  back_state_t state_r, state_nxt;

  itoa_base_t            base_r, base_nxt;
  logic [7:0]            fill_ch_r, fill_ch_nxt;
  logic [7:0]            sign_ch_r, sign_ch_nxt;
  logic                  sign_pend_r, sign_pend_nxt;
  logic [CNT_W-1:0]      width_r, width_nxt;
  logic [VALUE_BITS-1:0] num_r, num_nxt;
  logic [QUO_W-1:0]      quo_r, quo_nxt;
  logic [CNT_W-1:0]      ndig_r, ndig_nxt;
  logic [CNT_W-1:0]      nfill_r, nfill_nxt;
  logic [CNT_W-1:0]      pos_r, pos_nxt;
  logic [DIGIT_W-1:0]    digits_r [VALUE_BITS];

  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [2*VALUE_BITS-1:0] prod;
  logic [DIGIT_W-1:0]    tens_low;
  logic [DIGIT_W-1:0]    dig;
  logic [VALUE_BITS-1:0] num_next_dig;
  logic                  dig_done;
  logic                  dig_we;
  logic [CNT_W-1:0]      ndig_inc;
  logic [CNT_W-1:0]      pos_dec;
  logic                  out_free;

  assign job_pop  = (state_r == ST_IDLE) && job_valid;
  assign out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.char_out = out_char_r;
  assign out_ch.last     = out_last_r;

  assign prod     = 64'(num_r) * 64'(DEC_RECIP);
  // Only the low digit of quotient times ten matters, since the remainder is below ten.
  assign tens_low = DIGIT_W'({quo_r[0], 3'b000}) + DIGIT_W'({quo_r[2:0], 1'b0});
  assign ndig_inc = ndig_r + 1'b1;
  assign pos_dec  = pos_r - 1'b1;

  always_comb begin
    case (base_r)
      BASE_HEX: begin
        dig          = num_r[3:0];
        num_next_dig = num_r >> 4;
      end
      BASE_BIN: begin
        dig          = DIGIT_W'(num_r[0]);
        num_next_dig = num_r >> 1;
      end
      BASE_DEC: begin
        dig          = num_r[3:0] - tens_low;
        num_next_dig = VALUE_BITS'(quo_r);
      end
      default: begin
        dig          = '0;
        num_next_dig = '0;
      end
    endcase
    dig_done = (num_next_dig == '0) || (ndig_r == CNT_W'(VALUE_BITS - 1));
  end

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    fill_ch_nxt   = fill_ch_r;
    sign_ch_nxt   = sign_ch_r;
    sign_pend_nxt = sign_pend_r;
    width_nxt     = width_r;
    num_nxt       = num_r;
    quo_nxt       = quo_r;
    ndig_nxt      = ndig_r;
    nfill_nxt     = nfill_r;
    pos_nxt       = pos_r;
    dig_we        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          base_nxt      = job.base;
          fill_ch_nxt   = job.fill_ch;
          sign_ch_nxt   = job.sign_ch;
          sign_pend_nxt = job.has_sign;
          width_nxt     = job.width;
          num_nxt       = job.value;
          ndig_nxt      = '0;
          state_nxt     = (job.base == BASE_DEC) ? ST_MUL : ST_DIG;
        end
      end
      ST_MUL: begin
        quo_nxt   = prod[2*VALUE_BITS-1:DEC_SHIFT];
        state_nxt = ST_DIG;
      end
      ST_DIG: begin
        dig_we   = 1'b1;
        ndig_nxt = ndig_inc;
        num_nxt  = num_next_dig;
        if (dig_done) begin
          nfill_nxt = (width_r > ndig_inc) ? width_r - ndig_inc : '0;
          pos_nxt   = ndig_inc;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = (base_r == BASE_DEC) ? ST_MUL : ST_DIG;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          // Fill is never the final character: at least one digit follows.
          if (nfill_r != '0) begin
            out_char_nxt = fill_ch_r;
            out_last_nxt = 1'b0;
            nfill_nxt    = nfill_r - 1'b1;
          end else if (sign_pend_r) begin
            out_char_nxt  = sign_ch_r;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = digit_char(digits_r[pos_dec[IDX_W-1:0]]);
            out_last_nxt = (pos_r == CNT_W'(1));
            pos_nxt      = pos_dec;
            if (pos_r == CNT_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r      <= base_nxt;
    fill_ch_r   <= fill_ch_nxt;
    sign_ch_r   <= sign_ch_nxt;
    sign_pend_r <= sign_pend_nxt;
    width_r     <= width_nxt;
    num_r       <= num_nxt;
    quo_r       <= quo_nxt;
    ndig_r      <= ndig_nxt;
    nfill_r     <= nfill_nxt;
    pos_r       <= pos_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    if (dig_we) begin
      digits_r[ndig_r[IDX_W-1:0]] <= dig;
    end
  end

endmodule

/* hdl/integer_to_ascii_converter.sv */
// Channel  Direction  Payload                                               Transfer
// in_ch    sink       value, base_select, zero_fill, sign_mode, field_width valid & ready
// out_ch   source     char_out, last                                        valid & ready
//
// The job is loaded, then its digits are made one per step (for decimal, a reciprocal
// multiply, then the remainder), then fill, sign and digits are sent; the character
// stream leaves one per cycle while the output is not stalled.
// A two-entry job queue lets the input take two more numbers while one converts.
// Synchronous active-low reset; no clearing pass. A stalled output holds its character.
// Top level; depends on itoa_pkg, itoa_in_if, itoa_out_if, itoa_front, itoa_queue, itoa_back.
module integer_to_ascii_converter import itoa_pkg::*; #(
  parameter int MAX_DIGITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  itoa_in_if.sink    in_ch,
  itoa_out_if.source out_ch
);

  itoa_q_status_t q_status;
  itoa_job_t      push_job;
  itoa_job_t      pop_job;
  logic           push;
  logic           pop;

  itoa_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  itoa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  itoa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_status.nonempty),
    .job       (pop_job),
    .job_pop   (pop),
    .out_ch    (out_ch)
  );

endmodule

/* hdl/itoa_checker.sv */
// Port-level checker of the integer to ASCII converter, bound to the top level.
// Depends on integer_to_ascii_converter_defines.svh.
`include "integer_to_ascii_converter_defines.svh"

module itoa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  `ITOA_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "output valid after reset")
  `ITOA_ASSERT(a_out_held, out_valid && !out_ready |=> out_valid, "output dropped while stalled")
  `ITOA_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_char) && $stable(out_last), "stalled output changed")
  `ITOA_ASSERT(a_last_is_digit, out_valid && out_last |-> (out_char >= 8'h30 && out_char <= 8'h39) || (out_char >= 8'h61 && out_char <= 8'h66), "final character is not a digit")

endmodule

bind integer_to_ascii_converter itoa_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.char_out),
  .out_last  (out_ch.last)
);

/* tb/tb_integer_to_ascii_converter.sv */
`timescale 1ns / 1ps
// Testbench of integer_to_ascii_converter: a scoreboard predicts every character of each
// number taken in and checks the character stream. Needs itoa_pkg, itoa_in_if, itoa_out_if.
module tb_integer_to_ascii_converter import itoa_pkg::*;;

  localparam int MAX_DIGITS = 32;
  localparam int unsigned WIDTH_CAP = (MAX_DIGITS < 32) ? MAX_DIGITS : 32;
  localparam int unsigned RANDOM_NUMBERS = 350;
  localparam int unsigned DRAIN_CYCLES = 120;

  // Base select codes; both bits set falls back to binary.
  localparam logic [1:0] SEL_HEX     = 2'd0;
  localparam logic [1:0] SEL_DEC     = 2'd1;
  localparam logic [1:0] SEL_BIN     = 2'd2;
  localparam logic [1:0] SEL_BIN_DEC = 2'd3;

  // Sign mode codes; both bits set gives a minus.
  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_MINUS = 2'd2;
  localparam logic [1:0] SIGN_BOTH  = 2'd3;

  localparam logic PAD_SPACE = 1'b0;
  localparam logic PAD_ZERO  = 1'b1;

  // Receiver behaviors.
  localparam int unsigned RX_ALWAYS = 0;
  localparam int unsigned RX_LIGHT  = 1;
  localparam int unsigned RX_HEAVY  = 2;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  base_select;
    logic        zero_fill;
    logic [1:0]  sign_mode;
    logic [5:0]  field_width;
  } itoa_number_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } itoa_char_t;

  class itoa_scoreboard;
    itoa_char_t  expected_chars[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Formats one accepted number and queues its characters.
    function void note_number(itoa_number_t n);
      logic [31:0] num;
      logic [31:0] rem;
      logic [7:0]  digits[32];
      logic [7:0]  fill_ch;
      int unsigned base;
      int unsigned width;
      int unsigned ndig;
      int unsigned nfill;
      int unsigned total;
      int unsigned k;
      itoa_char_t  c;

      base = n.base_select[1] ? 2 : (n.base_select[0] ? 10 : 16);
      width = 32'(n.field_width);
      if (width > WIDTH_CAP) begin
        width = WIDTH_CAP;
      end

      num = n.value;
      ndig = 0;
      do begin
        rem = num % base;
        digits[ndig] = (rem <= 9) ? CH_ZERO + 8'(rem) : CH_LOWER_A + 8'(rem - 10);
        ndig++;
        num = num / base;
      end while (num != 0 && ndig < 32);

      nfill = (width > ndig) ? width - ndig : 0;
      fill_ch = n.zero_fill ? CH_ZERO : CH_SPACE;
      total = nfill + ndig + ((n.sign_mode != SIGN_NONE) ? 1 : 0);

      k = 0;
      for (int unsigned i = 0; i < nfill; i++) begin
        c.ch = fill_ch;
        c.last = (k + 1 == total);
        expected_chars.push_back(c);
        k++;
      end
      if (n.sign_mode != SIGN_NONE) begin
        c.ch = n.sign_mode[1] ? CH_MINUS : CH_PLUS;
        c.last = 1'b0;
        expected_chars.push_back(c);
        k++;
      end
      for (int unsigned i = ndig; i > 0; i--) begin
        c.ch = digits[i - 1];
        c.last = (i == 1);
        expected_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      itoa_char_t exp_c;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, got char %h last %b",
                 $time, ch, last);
        errors++;
        return;
      end
      exp_c = expected_chars.pop_front();
      if (ch !== exp_c.ch) begin
        $display("%0t: char_out mismatch, expected %h, got %h", $time, exp_c.ch, ch);
        errors++;
      end
      if (last !== exp_c.last) begin
        $display("%0t: last mismatch, expected %b, got %b", $time, exp_c.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  itoa_in_if  in_ch();
  itoa_out_if out_ch();

  integer_to_ascii_converter #(.MAX_DIGITS(MAX_DIGITS)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  itoa_scoreboard sb = new();
  itoa_number_t   numbers_to_send[$];
  int unsigned    rx_mode;
  int unsigned    rx_left;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  initial begin
    #10ms;
    $display("tb_integer_to_ascii_converter NOT OK");
    $finish;
  end

  // Both channels are observed here so that a number is noted before its characters.
  always @(posedge clk) begin
    itoa_number_t n;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        n.value = in_ch.value;
        n.base_select = in_ch.base_select;
        n.zero_fill = in_ch.zero_fill;
        n.sign_mode = in_ch.sign_mode;
        n.field_width = in_ch.field_width;
        sb.note_number(n);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_char(out_ch.char_out, out_ch.last);
      end
    end
  end

  // The receiver switches between stretches of no stalls, light stalls and heavy stalls.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(RX_ALWAYS, RX_HEAVY);
      rx_left = $urandom_range(8, 60);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_ALWAYS: out_ch.ready <= 1'b1;
      RX_LIGHT:  out_ch.ready <= ($urandom_range(0, 3) != 0);
      default:   out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic itoa_number_t make_number(logic [31:0] value, logic [1:0] base_select,
                                               logic zero_fill, logic [1:0] sign_mode,
                                               logic [5:0] field_width);
    itoa_number_t n;
    n.value = value;
    n.base_select = base_select;
    n.zero_fill = zero_fill;
    n.sign_mode = sign_mode;
    n.field_width = field_width;
    return n;
  endfunction

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0:       v = $urandom_range(0, 20);
      1:       v = $urandom >> $urandom_range(0, 31);
      2:       v = 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Holds valid high across each transfer and returns right after the accepting edge.
  task automatic send_number(itoa_number_t n);
    in_ch.valid <= 1'b1;
    in_ch.value <= n.value;
    in_ch.base_select <= n.base_select;
    in_ch.zero_fill <= n.zero_fill;
    in_ch.sign_mode <= n.sign_mode;
    in_ch.field_width <= n.field_width;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_all();
    int unsigned idx;
    int unsigned burst;
    int unsigned gap;
    idx = 0;
    while (idx < numbers_to_send.size()) begin
      burst = $urandom_range(1, 12);
      for (int unsigned b = 0; b < burst && idx < numbers_to_send.size(); b++) begin
        send_number(numbers_to_send[idx]);
        idx++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    itoa_number_t n;
    rst_n = 1'b0;
    rx_mode = RX_ALWAYS;
    rx_left = 0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.base_select = SEL_HEX;
    in_ch.zero_fill = PAD_SPACE;
    in_ch.sign_mode = SIGN_NONE;
    in_ch.field_width = '0;
    out_ch.ready = 1'b0;

    // Extremes of value and width, every base and sign code, and the fill boundaries.
    numbers_to_send.push_back(make_number(32'd0, SEL_HEX, PAD_SPACE, SIGN_NONE, 6'd0));
    numbers_to_send.push_back(make_number(32'd0, SEL_DEC, PAD_ZERO, SIGN_PLUS, 6'd32));
    numbers_to_send.push_back(make_number(32'd0, SEL_BIN, PAD_SPACE, SIGN_MINUS, 6'd33));
    numbers_to_send.push_back(make_number(32'hFFFF_FFFF, SEL_HEX, PAD_ZERO, SIGN_MINUS,
                                          6'd0));
    numbers_to_send.push_back(make_number(32'hFFFF_FFFF, SEL_DEC, PAD_ZERO, SIGN_PLUS,
                                          6'd10));
    numbers_to_send.push_back(make_number(32'hFFFF_FFFF, SEL_BIN, PAD_ZERO, SIGN_NONE,
                                          6'd32));
    numbers_to_send.push_back(make_number(32'hFFFF_FFFF, SEL_BIN, PAD_SPACE, SIGN_BOTH,
                                          6'd63));
    numbers_to_send.push_back(make_number(32'hDEAD_BEEF, SEL_HEX, PAD_ZERO, SIGN_NONE,
                                          6'd5));
    numbers_to_send.push_back(make_number(32'd12345, SEL_BIN_DEC, PAD_ZERO, SIGN_PLUS,
                                          6'd20));
    numbers_to_send.push_back(make_number(32'd9, SEL_DEC, PAD_SPACE, SIGN_NONE, 6'd1));
    numbers_to_send.push_back(make_number(32'd10, SEL_DEC, PAD_ZERO, SIGN_BOTH, 6'd3));
    numbers_to_send.push_back(make_number(32'hABCD_EF01, SEL_HEX, PAD_SPACE, SIGN_PLUS,
                                          6'd12));
    numbers_to_send.push_back(make_number(32'd1, SEL_BIN, PAD_ZERO, SIGN_NONE, 6'd32));
    numbers_to_send.push_back(make_number(32'h8000_0000, SEL_BIN, PAD_SPACE, SIGN_MINUS,
                                          6'd0));
    numbers_to_send.push_back(make_number(32'hFFFF_FFFF, SEL_DEC, PAD_SPACE, SIGN_NONE,
                                          6'd11));
    numbers_to_send.push_back(make_number(32'd255, SEL_HEX, PAD_ZERO, SIGN_NONE, 6'd2));
    numbers_to_send.push_back(make_number(32'd100, SEL_DEC, PAD_SPACE, SIGN_MINUS, 6'd32));
    numbers_to_send.push_back(make_number(32'd7, SEL_BIN_DEC, PAD_SPACE, SIGN_BOTH, 6'd0));
    numbers_to_send.push_back(make_number(32'h0000_000F, SEL_HEX, PAD_ZERO, SIGN_PLUS,
                                          6'd40));

    for (int unsigned i = 0; i < RANDOM_NUMBERS; i++) begin
      n.value = random_value();
      n.base_select = 2'($urandom_range(0, 3));
      n.zero_fill = 1'($urandom_range(0, 1));
      n.sign_mode = 2'($urandom_range(0, 3));
      n.field_width = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, 34));
      numbers_to_send.push_back(n);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_all();
    // Let the monitor note the final transfer before the queue is polled.
    @(posedge clk);

    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_integer_to_ascii_converter OK");
    end else begin
      $display("tb_integer_to_ascii_converter NOT OK");
    end
    $finish;
  end

endmodule
